### hdl/iff_pkg.sv
package iff_pkg;

  typedef enum logic [1:0] {
    KIND_SDEC = 2'd0,
    KIND_UDEC = 2'd1,
    KIND_OCT  = 2'd2,
    KIND_HEX  = 2'd3
  } kind_t;

  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_LONG  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_X     = 8'h78;

  // one classified request, passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [63:0] mag;
    logic        zero_val;
    logic        no_digit;
    logic [7:0]  pfx0;
    logic [7:0]  pfx1;
    logic [1:0]  np;
    logic        left;
    logic        zero_mode;
    logic        alt_oct;
    logic [6:0]  fw;
    logic [6:0]  pr;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_PLAN,
    ST_EMIT
  } back_state_t;

endpackage

### hdl/iff_front.sv
module iff_front #(
  parameter int MAX_FIELD_CHARS = 64,
  parameter int MAX_PRECISION   = 60
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [63:0]      value_bits,
  input  logic [1:0]       size_sel,
  input  logic             plus_flag,
  input  logic             left_flag,
  input  logic             zero_pad,
  input  logic             space_flag,
  input  logic             alt_flag,
  input  logic [6:0]       field_width,
  input  logic [5:0]       precision,
  input  logic             precision_given,
  output logic             q_valid,
  input  logic             q_ready,
  output iff_pkg::req_t    q_req
);

  iff_pkg::req_t slot_r [2];
  logic [1:0]    cnt_r;
  logic          wp_r, rp_r;
  iff_pkg::req_t cls;
  logic [63:0]   v, mask;
  logic          neg;
  logic [6:0]    fwsat, prsat;
  logic          push, pop;

  always_comb begin
    if (size_sel == iff_pkg::SIZE_LONG) mask = '1;
    else if (size_sel == iff_pkg::SIZE_SHORT && kind != iff_pkg::KIND_HEX) mask = 64'hffff;
    else mask = 64'hffff_ffff;
    v = value_bits & mask;
    if (size_sel == iff_pkg::SIZE_LONG) neg = v[63];
    else if (size_sel == iff_pkg::SIZE_SHORT) neg = v[15];
    else neg = v[31];
    neg = neg && (kind == iff_pkg::KIND_SDEC);
    fwsat = (field_width > 7'(MAX_FIELD_CHARS)) ? 7'(MAX_FIELD_CHARS) : field_width;
    prsat = 7'(precision);
    if (prsat > 7'(MAX_PRECISION)) prsat = 7'(MAX_PRECISION);
    if (!precision_given) prsat = '0;
    cls.kind      = iff_pkg::kind_t'(kind);
    cls.mag       = neg ? ((64'd0 - v) & mask) : v;
    cls.zero_val  = (v == 64'd0);
    cls.no_digit  = (v == 64'd0) && precision_given && (precision == 6'd0);
    cls.pfx0      = iff_pkg::CH_ZERO;
    cls.pfx1      = iff_pkg::CH_X;
    cls.np        = 2'd0;
    if (kind == iff_pkg::KIND_SDEC) begin
      cls.np = 2'd1;
      if (neg) cls.pfx0 = iff_pkg::CH_MINUS;
      else if (plus_flag) cls.pfx0 = iff_pkg::CH_PLUS;
      else if (space_flag) cls.pfx0 = iff_pkg::CH_SPACE;
      else cls.np = 2'd0;
    end else if (kind == iff_pkg::KIND_HEX && alt_flag && v != 64'd0) begin
      cls.np = 2'd2;
    end
    cls.left      = left_flag;
    cls.zero_mode = zero_pad && !left_flag && !precision_given;
    cls.alt_oct   = alt_flag && (kind == iff_pkg::KIND_OCT);
    cls.fw        = fwsat;
    cls.pr        = prsat;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= cls;
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("accepted into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
`endif

endmodule

### hdl/iff_back.sv
module iff_back #(
  parameter int MAX_FIELD_CHARS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  iff_pkg::req_t q_req,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_char,
  output logic          out_last
);

  // reciprocal of ten for 32-bit and 33-bit dividends, and 2^32 / 10
  localparam logic [31:0] DIV10_M     = 32'hcccc_cccd;
  localparam logic [31:0] TWO32_DIV10 = 32'd429496729;

  iff_pkg::back_state_t st_r, st_nxt;
  iff_pkg::req_t        req_r;
  logic [63:0] mag_r;
  logic [3:0]  dig_r [24];
  logic [4:0]  nd_r;
  logic [6:0]  pos_r, len_r;
  logic [6:0]  a0_r, a1_r, a2_r, a3_r; // section boundaries
  logic [7:0]  ch_r;
  logic        vld_r, last_r;
  logic [1:0]  ph_r;
  logic [31:0] qh_r;
  logic [3:0]  rh_r;
  logic [32:0] t_r;

  logic [3:0]  dnext;
  logic [63:0] qnext;
  logic [63:0] hprod;
  logic [64:0] tprod;
  logic [3:0]  rh;
  logic [31:0] tq, qlo;
  logic [3:0]  trem;
  logic        dec_kind;

  assign dec_kind = req_r.kind inside {iff_pkg::KIND_SDEC, iff_pkg::KIND_UDEC};

  // divide by ten in three steps: upper half, remainder carried into the lower half,
  // lower half; octal and hex by shift
  always_comb begin
    hprod = mag_r[63:32] * DIV10_M;
    rh    = 4'(mag_r[63:32] - qh_r * 32'd10);
    tprod = t_r * DIV10_M;
    tq    = 32'(tprod >> 35);
    trem  = 4'(t_r - {1'b0, tq} * 33'd10);
    qlo   = 32'(rh_r) * TWO32_DIV10 + tq;
    case (req_r.kind)
      iff_pkg::KIND_OCT: begin dnext = {1'b0, mag_r[2:0]}; qnext = mag_r >> 3; end
      iff_pkg::KIND_HEX: begin dnext = mag_r[3:0]; qnext = mag_r >> 4; end
      default:           begin dnext = trem; qnext = {qh_r, qlo}; end
    endcase
  end

  logic [6:0] zeros_c, len_c, pad_c, total_c;
  logic [1:0] np;
  always_comb begin
    zeros_c = (req_r.pr > 7'(nd_r)) ? req_r.pr - 7'(nd_r) : 7'd0;
    if (req_r.alt_oct && zeros_c == 7'd0 && !(nd_r != 5'd0 && dig_r[nd_r - 5'd1] == 4'd0))
      zeros_c = zeros_c + 7'd1;
    np      = req_r.np;
    len_c   = 7'(np) + zeros_c + 7'(nd_r);
    pad_c   = (req_r.fw > len_c) ? req_r.fw - len_c : 7'd0;
    total_c = len_c + pad_c;
  end

  logic [7:0] ch_c;
  logic [4:0] di;
  logic [3:0] dv;
  always_comb begin
    di = 5'(a3_r - pos_r - 7'd1);
    dv = dig_r[di];
    if (pos_r < a0_r) ch_c = req_r.zero_mode ? iff_pkg::CH_ZERO : iff_pkg::CH_SPACE;
    else if (pos_r < a1_r) ch_c = (pos_r == a1_r - 7'(np)) ? req_r.pfx0 : req_r.pfx1;
    else if (pos_r < a2_r) ch_c = iff_pkg::CH_ZERO;
    else if (pos_r < a3_r)
      ch_c = (dv < 4'd10) ? iff_pkg::CH_ZERO + 8'(dv) : iff_pkg::CH_A + 8'(dv - 4'd10);
    else ch_c = iff_pkg::CH_SPACE;
  end

  logic want_dig;
  assign want_dig = (st_r == iff_pkg::ST_DIGIT) &&
                    ((mag_r != 64'd0 && nd_r != 5'd24) ||
                     (req_r.zero_val && !req_r.no_digit && nd_r == 5'd0));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      iff_pkg::ST_IDLE:  if (q_valid) st_nxt = iff_pkg::ST_DIGIT;
      iff_pkg::ST_DIGIT: if (!want_dig) st_nxt = iff_pkg::ST_PLAN;
      iff_pkg::ST_PLAN:  st_nxt = iff_pkg::ST_EMIT;
      iff_pkg::ST_EMIT:  if (pos_r >= len_r && (!vld_r || out_tready)) st_nxt = iff_pkg::ST_IDLE;
      default:           st_nxt = iff_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (st_r == iff_pkg::ST_IDLE);
  end

  logic dig_step;
  assign dig_step = want_dig && (!dec_kind || ph_r == 2'd2);

  always_ff @(posedge clk) begin
    if (st_r == iff_pkg::ST_IDLE && q_valid) begin
      req_r <= q_req;
      mag_r <= q_req.mag;
    end
    if (ph_r == 2'd0) qh_r <= 32'(hprod >> 35);
    if (ph_r == 2'd1) begin
      rh_r <= rh;
      t_r  <= 33'(mag_r[31:0]) + 33'(rh) * 33'd6;
    end
    if (dig_step) begin
      dig_r[nd_r] <= dnext;
      mag_r <= qnext;
    end
    if (st_r == iff_pkg::ST_PLAN) begin
      len_r <= (total_c > 7'(MAX_FIELD_CHARS)) ? 7'(MAX_FIELD_CHARS) : total_c;
      a0_r <= req_r.left ? 7'd0 : (req_r.zero_mode ? 7'd0 : pad_c);
      a1_r <= (req_r.left || req_r.zero_mode ? 7'd0 : pad_c) + 7'(np);
      a2_r <= (req_r.left ? 7'd0 : pad_c) + 7'(np) + zeros_c;
      a3_r <= (req_r.left ? 7'd0 : pad_c) + 7'(np) + zeros_c + 7'(nd_r);
    end
    if (!vld_r || out_tready) begin
      ch_r   <= ch_c;
      last_r <= (pos_r + 7'd1 == len_r);
    end
    if (!rst_n) begin
      st_r  <= iff_pkg::ST_IDLE;
      nd_r  <= '0;
      pos_r <= '0;
      vld_r <= 1'b0;
      ph_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (want_dig && dec_kind && ph_r != 2'd2) ph_r <= ph_r + 2'd1;
      else ph_r <= '0;
      if (st_r == iff_pkg::ST_IDLE) nd_r <= '0;
      else if (dig_step) nd_r <= nd_r + 5'd1;
      if (st_r == iff_pkg::ST_PLAN) pos_r <= '0;
      if (!vld_r || out_tready) begin
        if (st_r == iff_pkg::ST_EMIT && pos_r < len_r) begin
          vld_r <= 1'b1;
          pos_r <= pos_r + 7'd1;
        end else vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = vld_r;
  assign out_char   = ch_r;
  assign out_last   = last_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_char))
    else $error("output changed while stalled");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == iff_pkg::ST_EMIT |-> len_r <= 7'(MAX_FIELD_CHARS)) else $error("field too long");
  a_nd: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= 5'd24) else $error("digit count overflow");
`endif

endmodule

### hdl/integer_field_formatter.sv
// printf-style integer formatter: a request (conversion, value, size, flags, width,
// precision) on the in_ side produces its text on the out_ side, one ASCII character
// per transfer with tlast on the final one; a request giving no text gives no transfer.
// a two-entry queue holds classified requests while the back end works. per request
// the back end picks it up, derives its digits (up to 22, for a 64-bit octal value),
// plans the field layout, then emits its characters (up to 64), stalling while
// out_tready is low.
module integer_field_formatter #(
  parameter int MAX_FIELD_CHARS = 64,
  parameter int MAX_PRECISION   = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[1:0], value_bits[65:2], size_sel[67:66], plus_flag[68], left_flag[69],
  // zero_pad[70], space_flag[71], alt_flag[72], field_width[79:73],
  // precision[85:80], precision_given[86], zero fill to 88 bits
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // character[7:0]
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  logic          q_valid, q_ready;
  iff_pkg::req_t q_req;

  iff_front #(.MAX_FIELD_CHARS(MAX_FIELD_CHARS), .MAX_PRECISION(MAX_PRECISION)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .kind(in_tdata[1:0]), .value_bits(in_tdata[65:2]), .size_sel(in_tdata[67:66]),
    .plus_flag(in_tdata[68]), .left_flag(in_tdata[69]), .zero_pad(in_tdata[70]),
    .space_flag(in_tdata[71]), .alt_flag(in_tdata[72]), .field_width(in_tdata[79:73]),
    .precision(in_tdata[85:80]), .precision_given(in_tdata[86]),
    .q_valid, .q_ready, .q_req
  );

  iff_back #(.MAX_FIELD_CHARS(MAX_FIELD_CHARS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_tvalid, .out_tready, .out_char(out_tdata), .out_last(out_tlast)
  );

endmodule
